### hdl/point_segment_distance_3d_top_defines.svh
// Assertion macros for the point to segment distance block.
`ifndef POINT_SEGMENT_DISTANCE_3D_TOP_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_3D_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
`define PSD_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`define PSD_ASSERT_RST(lbl, b) \
  lbl: assert property (@(posedge clk) !rst_n |=> (b)) \
    else $error("reset check failed");
`else
`define PSD_ASSERT_IMPL(lbl, a, b)
`define PSD_ASSERT_NEXT(lbl, a, b)
`define PSD_ASSERT_RST(lbl, b)
`endif
`endif

### hdl/psd_pkg.sv
package psd_pkg;
  // working word of the CORDIC datapath
  localparam int W = 64;
  localparam logic [30:0] INV_GAIN = 31'd1304065748;
  typedef logic signed [W-1:0] word_t;
endpackage

### hdl/psd_cordic_cell.sv
module psd_cordic_cell #(
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  psd_pkg::word_t       gx_i,
  input  psd_pkg::word_t       gy_i,
  input  psd_pkg::word_t       cx_i,
  input  psd_pkg::word_t       cy_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output psd_pkg::word_t       gx_o,
  output psd_pkg::word_t       gy_o,
  output psd_pkg::word_t       cx_o,
  output psd_pkg::word_t       cy_o,
  output logic [SIDE_W-1:0]    side_o
);
  psd_pkg::word_t gx_nxt, gy_nxt, cx_nxt, cy_nxt;
  psd_pkg::word_t gx_r, gy_r, cx_r, cy_r;
  logic [SIDE_W-1:0] side_r;
  logic valid_r;

  always_comb begin
    if (gy_i >= 0) begin
      gx_nxt = gx_i + (gy_i >>> SHIFT);
      gy_nxt = gy_i - (gx_i >>> SHIFT);
      cx_nxt = cx_i + (cy_i >>> SHIFT);
      cy_nxt = cy_i - (cx_i >>> SHIFT);
    end else begin
      gx_nxt = gx_i - (gy_i >>> SHIFT);
      gy_nxt = gy_i + (gx_i >>> SHIFT);
      cx_nxt = cx_i - (cy_i >>> SHIFT);
      cy_nxt = cy_i + (cx_i >>> SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r   <= gx_nxt;
      gy_r   <= gy_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign gx_o = gx_r;
  assign gy_o = gy_r;
  assign cx_o = cx_r;
  assign cy_o = cy_r;
  assign side_o = side_r;
endmodule

### hdl/psd_unscale.sv
module psd_unscale (
  input  logic           clk,
  input  logic           en,
  input  psd_pkg::word_t a_i,
  output psd_pkg::word_t r_o
);
  localparam int W = psd_pkg::W;
  logic             neg_r;
  logic [W-1:0]     mag;
  logic [W-1:0]     p_hi_nxt, p_hi_r;
  logic [61:0]      lo_prod;
  logic [30:0]      p_lo_r;
  logic [W-1:0]     sum;
  psd_pkg::word_t   r_r;

  always_comb begin
    mag      = (a_i < 0) ? W'(-a_i) : W'(a_i);
    p_hi_nxt = W'(W'(mag[W-1:31]) * W'(psd_pkg::INV_GAIN));
    lo_prod  = 62'(mag[30:0]) * 62'(psd_pkg::INV_GAIN);
    sum      = p_hi_r + W'(p_lo_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= a_i < 0;
      p_hi_r <= p_hi_nxt;
      p_lo_r <= lo_prod[61:31];
      r_r    <= neg_r ? -$signed(sum) : $signed(sum);
    end
  end

  assign r_o = r_r;
endmodule

### hdl/psd_cordic.sv
module psd_cordic #(
  parameter int STAGES = 24,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  psd_pkg::word_t    x_i,
  input  psd_pkg::word_t    y_i,
  input  psd_pkg::word_t    p_i,
  input  psd_pkg::word_t    q_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output psd_pkg::word_t    x_o,
  output psd_pkg::word_t    p_o,
  output psd_pkg::word_t    q_o,
  output logic [SIDE_W-1:0] side_o
);
  psd_pkg::word_t    gx [0:STAGES];
  psd_pkg::word_t    gy [0:STAGES];
  psd_pkg::word_t    cx [0:STAGES];
  psd_pkg::word_t    cy [0:STAGES];
  logic [SIDE_W-1:0] sd [0:STAGES];
  logic              vl [0:STAGES];
  logic [1:0]        vl_r;
  logic [SIDE_W-1:0] sd1_r, sd2_r;

  // turn a left-half vector by 180 degrees first
  always_comb begin
    vl[0] = valid_i;
    sd[0] = side_i;
    if (x_i < 0) begin
      gx[0] = -x_i;
      gy[0] = -y_i;
      cx[0] = -p_i;
      cy[0] = -q_i;
    end else begin
      gx[0] = x_i;
      gy[0] = y_i;
      cx[0] = p_i;
      cy[0] = q_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    psd_cordic_cell #(.SHIFT(i), .SIDE_W(SIDE_W)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(vl[i]), .gx_i(gx[i]), .gy_i(gy[i]), .cx_i(cx[i]), .cy_i(cy[i]),
      .side_i(sd[i]),
      .valid_o(vl[i+1]), .gx_o(gx[i+1]), .gy_o(gy[i+1]), .cx_o(cx[i+1]),
      .cy_o(cy[i+1]), .side_o(sd[i+1])
    );
  end

  psd_unscale u_ux (.clk(clk), .en(en), .a_i(gx[STAGES]), .r_o(x_o));
  psd_unscale u_up (.clk(clk), .en(en), .a_i(cx[STAGES]), .r_o(p_o));
  psd_unscale u_uq (.clk(clk), .en(en), .a_i(cy[STAGES]), .r_o(q_o));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= 2'b00;
    end else if (en) begin
      vl_r <= {vl_r[0], vl[STAGES]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r <= sd[STAGES];
      sd2_r <= sd1_r;
    end
  end

  assign valid_o = vl_r[1];
  assign side_o  = sd2_r;
endmodule

### hdl/point_segment_distance_3d_top.sv
// Point to segment distance in 3D, fully pipelined.
// Input channel: in_valid / in_stall carries one query word: segment start,
// segment end, query point (signed, COORD_WIDTH bits each) and a radius.
// Output channel: out_valid / out_stall carries the distance (unsigned, same
// scale, saturated at all ones) and the within_radius flag.
// A word is taken at a clock edge where valid is high and stall is low.
// Throughput: one query per cycle while out_stall does not hold the output.
// Stages: one input register, four CORDIC chains of CORDIC_STAGES cells
// plus two gain-compensation stages each, one projection-test stage and the
// output register.
// The whole pipeline advances as one; when the output holds a result that
// is stalled, every stage holds and in_stall rises in the same cycle.
// Reset (synchronous, rst_n low) empties the pipeline: all valid bits clear,
// so in-flight queries are dropped.
`include "point_segment_distance_3d_top_defines.svh"
module point_segment_distance_3d_top #(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_seg_start_z,
  input  logic signed [COORD_WIDTH-1:0] in_seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_seg_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_seg_end_z,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic        [COORD_WIDTH-2:0] in_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic        [COORD_WIDTH-1:0] out_distance,
  output logic                          out_within_radius
);
  localparam int W     = psd_pkg::W;
  localparam int CW    = COORD_WIDTH;
  localparam int RW    = CW - 1;
  localparam int GUARD = 58 - CW;

  typedef psd_pkg::word_t word_t;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  function automatic word_t diff_up(input logic signed [CW-1:0] a,
                                    input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    word_t e;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    e = $signed({{(W-CW-1){d[CW]}}, d});
    return e <<< GUARD;
  endfunction

  // input stage
  logic v0_r;
  word_t dx_r, dy_r, dz_r, wx_r, wy_r, wz_r;
  logic [RW-1:0] rad0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r   <= diff_up(in_seg_end_x, in_seg_start_x);
      dy_r   <= diff_up(in_seg_end_y, in_seg_start_y);
      dz_r   <= diff_up(in_seg_end_z, in_seg_start_z);
      wx_r   <= diff_up(in_point_x, in_seg_start_x);
      wy_r   <= diff_up(in_point_y, in_seg_start_y);
      wz_r   <= diff_up(in_point_z, in_seg_start_z);
      rad0_r <= in_radius;
    end
  end

  // x-z plane
  localparam int S1_W = 2 * W + RW;
  logic v1;
  word_t x1, p1, q1;
  logic [S1_W-1:0] s1;
  psd_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(S1_W)) u_c1 (
    .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(v0_r),
    .x_i(dx_r), .y_i(dz_r), .p_i(wx_r), .q_i(wz_r),
    .side_i({dy_r, wy_r, rad0_r}),
    .valid_o(v1), .x_o(x1), .p_o(p1), .q_o(q1), .side_o(s1)
  );

  // x-y plane
  localparam int S2_W = W + RW;
  logic v2;
  word_t len2, u2, v2w;
  logic [S2_W-1:0] s2;
  psd_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(S2_W)) u_c2 (
    .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(v1),
    .x_i(x1), .y_i(word_t'(s1[S1_W-1 -: W])), .p_i(p1),
    .q_i(word_t'(s1[RW +: W])),
    .side_i({q1, s1[RW-1:0]}),
    .valid_o(v2), .x_o(len2), .p_o(u2), .q_o(v2w), .side_o(s2)
  );

  // perpendicular length
  localparam int S3_W = 2 * W + RW;
  logic v3;
  word_t perp3;
  logic [S3_W-1:0] s3;
  psd_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(S3_W)) u_c3 (
    .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(v2),
    .x_i(v2w), .y_i(word_t'(s2[S2_W-1 -: W])), .p_i('0), .q_i('0),
    .side_i({u2, len2, s2[RW-1:0]}),
    .valid_o(v3), .x_o(perp3), .p_o(), .q_o(), .side_o(s3)
  );

  // projection test and nearer endpoint offset
  word_t u3, len3, au, ad, d2;
  assign u3   = word_t'(s3[S3_W-1 -: W]);
  assign len3 = word_t'(s3[RW +: W]);
  assign d2   = u3 - len3;
  assign au   = (u3 < 0) ? -u3 : u3;
  assign ad   = (d2 < 0) ? -d2 : d2;

  logic vm_r, inside_r;
  word_t perpm_r, mn_r;
  logic [RW-1:0] radm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (adv) begin
      vm_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r <= (u3 >= 0) && (u3 <= len3);
      perpm_r  <= perp3;
      mn_r     <= (au < ad) ? au : ad;
      radm_r   <= s3[RW-1:0];
    end
  end

  // endpoint distance
  localparam int S4_W = W + 1 + RW;
  logic v4;
  word_t mag4;
  logic [S4_W-1:0] s4;
  psd_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(S4_W)) u_c4 (
    .clk(clk), .rst_n(rst_n), .en(adv), .valid_i(vm_r),
    .x_i(mn_r), .y_i(perpm_r), .p_i('0), .q_i('0),
    .side_i({perpm_r, inside_r, radm_r}),
    .valid_o(v4), .x_o(mag4), .p_o(), .q_o(), .side_o(s4)
  );

  // round, saturate, compare
  word_t dist_sel;
  logic [W-1:0] rnd;
  logic [CW-1:0] dsat;
  logic [W-1:0] max_out;
  always_comb begin
    max_out = (W'(1) << CW) - W'(1);
    dist_sel = s4[RW] ? word_t'(s4[S4_W-1 -: W]) : mag4;
    if (dist_sel < 0) begin
      dist_sel = '0;
    end
    rnd  = (W'(dist_sel) + (W'(1) << (GUARD - 1))) >> GUARD;
    dsat = (rnd > max_out) ? {CW{1'b1}} : rnd[CW-1:0];
  end

  logic out_valid_r, within_r;
  logic [CW-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r   <= dsat;
      within_r <= dsat <= CW'(s4[RW-1:0]);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_distance      = dist_r;
  assign out_within_radius = within_r;

  `PSD_ASSERT_IMPL(a_stall_follows_out, 1'b1, in_stall == (out_valid && out_stall))
  `PSD_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(out_distance))
  `PSD_ASSERT_RST(a_reset_empty, !out_valid && !v4 && !vm_r && !v0_r)
endmodule

### tb/sv/psd_distance_checker.sv
module psd_distance_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_seg_start_x,
  input  logic [31:0] in_seg_start_y,
  input  logic [31:0] in_seg_start_z,
  input  logic [31:0] in_seg_end_x,
  input  logic [31:0] in_seg_end_y,
  input  logic [31:0] in_seg_end_z,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic [31:0] in_point_z,
  input  logic [30:0] in_radius,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_distance,
  input  logic        out_within_radius,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GUARD = 26;
  localparam int STAGES = 24;
  localparam longint unsigned INV_GAIN_K = 64'd1304065748;

  typedef struct packed {
    logic [31:0] distance;
    logic        in_range;
  } dist_result_t;

  dist_result_t expected_q[$];

  function automatic longint floor_shift(longint v, int s);
    if (v < 0) return -1 - ((-1 - v) >>> s);
    return v >>> s;
  endfunction

  // multiply by inverse CORDIC gain, truncating toward zero
  function automatic longint gain_fix(longint a);
    longint unsigned m;
    longint unsigned r;
    m = (a < 0) ? longint'(-a) : a;
    r = (m >> 31) * INV_GAIN_K + (((m & 64'h7FFF_FFFF) * INV_GAIN_K) >> 31);
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void rotate_vec(inout longint x, inout longint y, inout longint p,
                                     inout longint q);
    longint nx, ny, mx, my;
    if (x < 0) begin
      x = -x; y = -y; p = -p; q = -q;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (y >= 0) begin
        nx = x + floor_shift(y, i); ny = y - floor_shift(x, i);
        mx = p + floor_shift(q, i); my = q - floor_shift(p, i);
      end else begin
        nx = x - floor_shift(y, i); ny = y + floor_shift(x, i);
        mx = p - floor_shift(q, i); my = q + floor_shift(p, i);
      end
      x = nx; y = ny; p = mx; q = my;
    end
    x = gain_fix(x); y = gain_fix(y); p = gain_fix(p); q = gain_fix(q);
  endfunction

  function automatic longint vec_length(longint a, longint b);
    longint p, q;
    p = 0; q = 0;
    rotate_vec(a, b, p, q);
    return a;
  endfunction

  function automatic dist_result_t predict_distance();
    longint dx, dy, dz, wx, wy, wz, len, u, perp, dist_v, au, ad;
    longint unsigned r;
    dist_result_t res;
    dx = (longint'($signed(in_seg_end_x)) - longint'($signed(in_seg_start_x))) <<< GUARD;
    dy = (longint'($signed(in_seg_end_y)) - longint'($signed(in_seg_start_y))) <<< GUARD;
    dz = (longint'($signed(in_seg_end_z)) - longint'($signed(in_seg_start_z))) <<< GUARD;
    wx = (longint'($signed(in_point_x)) - longint'($signed(in_seg_start_x))) <<< GUARD;
    wy = (longint'($signed(in_point_y)) - longint'($signed(in_seg_start_y))) <<< GUARD;
    wz = (longint'($signed(in_point_z)) - longint'($signed(in_seg_start_z))) <<< GUARD;
    rotate_vec(dx, dz, wx, wz);
    len = dx;
    rotate_vec(len, dy, wx, wy);
    u = wx;
    perp = vec_length(wy, wz);
    if (u >= 0 && u <= len) begin
      dist_v = perp;
    end else begin
      au = (u < 0) ? -u : u;
      ad = (u - len < 0) ? len - u : u - len;
      dist_v = vec_length((au < ad) ? au : ad, perp);
    end
    if (dist_v < 0) dist_v = 0;
    r = (longint'(dist_v) + (64'd1 << (GUARD - 1))) >> GUARD;
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    res.distance = r[31:0];
    res.in_range = (r <= {33'd0, in_radius});
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    dist_result_t want;
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(predict_distance());
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", out_distance, -1);
        end else begin
          want = expected_q.pop_front();
          if (out_distance !== want.distance)
            report_mismatch("distance", out_distance, want.distance);
          if (out_within_radius !== want.in_range)
            report_mismatch("within_radius", out_within_radius, want.in_range);
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

### tb/sv/tb_point_segment_distance_3d_top.sv
module tb_point_segment_distance_3d_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 107;
  localparam int N_RANDOM = 830;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_seg_start_x = 0, in_seg_start_y = 0, in_seg_start_z = 0;
  logic signed [31:0] in_seg_end_x = 0, in_seg_end_y = 0, in_seg_end_z = 0;
  logic signed [31:0] in_point_x = 0, in_point_y = 0, in_point_z = 0;
  logic [30:0] in_radius = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] out_distance;
  logic out_within_radius;
  int fail_count;
  int pending;
  bit quiet_tail = 0;
  bit hold_long = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  point_segment_distance_3d_top DUT (.*);

  psd_distance_checker checker_i (.*);

  typedef logic signed [31:0] coord_t;
  localparam coord_t CMAX = 32'sh7FFF_FFFF;
  localparam coord_t CMIN = 32'sh8000_0000;

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return ($urandom_range(0, 1)) ? CMAX - $urandom_range(0, 3)
                                       : CMIN + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  // present one word and hold it until accepted
  task automatic send_word(coord_t sx, coord_t sy, coord_t sz, coord_t ex, coord_t ey,
                           coord_t ez, coord_t px, coord_t py, coord_t pz,
                           logic [30:0] rad);
    in_valid <= 1;
    in_seg_start_x <= sx; in_seg_start_y <= sy; in_seg_start_z <= sz;
    in_seg_end_x <= ex; in_seg_end_y <= ey; in_seg_end_z <= ez;
    in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    in_radius <= rad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic maybe_gap();
    int n;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver stalls
  initial begin
    int n;
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long && !held) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        out_stall <= 0;
        held = 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb_point_segment_distance_3d_top: FAIL");
    $finish;
  end

  initial begin
    coord_t s0, s1, s2, e0, e1, e2;
    int mode, wait_cycles;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: zero-length, extremes, inside/outside projection, radius edges
    send_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(32'sh10000, 32'sh20000, 0, 32'sh10000, 32'sh20000, 0, 32'sh50000, 32'sh60000,
              0, 31'h50000);
    send_word(0, 0, 0, 32'sh100000, 0, 0, 32'sh80000, 32'sh30000, 0, 31'h30000);
    send_word(0, 0, 0, 32'sh100000, 0, 0, 32'sh80000, 32'sh30000, 0, 31'h2FFFF);
    send_word(0, 0, 0, 32'sh100000, 0, 0, -32'sh30000, 0, 0, 31'h30000);
    send_word(0, 0, 0, 32'sh100000, 0, 0, 32'sh140000, 0, 0, 31'h40000);
    send_word(0, 0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 32'sh8000, 31'h7FFF_FFFF);
    send_word(0, 0, 0, 0, 32'sh10000, 0, 0, 0, 0, 0);
    send_word(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, 31'h7FFF_FFFF);
    send_word(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 31'h7FFF_FFFF);
    send_word(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);
    send_word(CMAX, CMIN, 0, CMIN, CMAX, 0, 0, 0, CMAX, 31'h5555_5555);
    send_word(-1, -1, -1, 1, 1, 1, 0, 0, 0, 1);
    send_word(32'sh0000FFFF, -32'sh00010000, 32'sh1234, 32'sh00010000, 32'sh0000FFFF,
              -32'sh1234, 32'sh2AAAAAAA, -32'sh55555555, 32'sh55555555, 31'h2AAA_AAAA);
    maybe_gap();
    // back-pressure: receiver holds while words keep coming
    hold_long = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 120) quiet_tail = 1;
      mode = $urandom_range(0, 3);
      s0 = rand_coord(mode); s1 = rand_coord(mode); s2 = rand_coord(mode);
      if ($urandom_range(0, 15) == 0) begin
        e0 = s0; e1 = s1; e2 = s2;
      end else begin
        e0 = rand_coord(mode); e1 = rand_coord(mode); e2 = rand_coord(mode);
      end
      send_word(s0, s1, s2, e0, e1, e2, rand_coord(mode), rand_coord(mode),
                rand_coord(mode),
                31'(($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 32'h0040_0000)));
      maybe_gap();
    end
    in_valid <= 0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_point_segment_distance_3d_top: PASS");
    else
      $display("tb_point_segment_distance_3d_top: FAIL");
    $finish;
  end
endmodule

### point_segment_distance_3d_top.f
+incdir+hdl
hdl/psd_pkg.sv
hdl/psd_cordic_cell.sv
hdl/psd_unscale.sv
hdl/psd_cordic.sv
hdl/point_segment_distance_3d_top.sv
tb/sv/psd_distance_checker.sv
tb/sv/tb_point_segment_distance_3d_top.sv
